[design/graph_transition_normalize_unit_assert.svh]
// assertion macros for the transition normalize block
// used by graph_transition_normalize_unit, no other dependencies
`ifndef GRAPH_TRANSITION_NORMALIZE_UNIT_ASSERT_SVH
`define GRAPH_TRANSITION_NORMALIZE_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define GTN_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("gtn assertion failed");

// next-cycle implication, disabled in reset
`define GTN_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("gtn assertion failed");

`endif

[design/gtn_pkg.sv]
// shared types and constants for the transition normalize block
// no dependencies
`default_nettype none
package gtn_pkg;
  localparam int MAX_NODES_DEF = 1024;
  localparam int MAX_EDGES_DEF = 4096;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam int NODE_FW   = 11;
  localparam int WGT_FW    = 16;
  localparam int NW_FW     = 17;
  localparam int QW_W      = 25;
  localparam int ROW_SHIFT = 24;
  localparam int COL_SHIFT = 16;
  localparam int DVD_W     = 41;
  localparam int DCNT_W    = 6;

  typedef logic [NODE_FW-1:0] node_t;
  typedef logic [WGT_FW-1:0]  wgt_t;
  typedef logic [NW_FW-1:0]   nw_t;
endpackage
`default_nettype wire

[design/gtn_in_if.sv]
// input channel of the transition normalize block
// depends on gtn_pkg
`default_nettype none
interface gtn_in_if;
  import gtn_pkg::*;
  logic  valid;
  logic  ready;
  logic  kind;
  node_t src_node;
  node_t dst_node;
  wgt_t  edge_weight;
  modport source (output valid, kind, src_node, dst_node, edge_weight, input ready);
  modport sink (input valid, kind, src_node, dst_node, edge_weight, output ready);
endinterface
`default_nettype wire

[design/gtn_out_if.sv]
// result channel of the transition normalize block
// depends on gtn_pkg
`default_nettype none
interface gtn_out_if;
  import gtn_pkg::*;
  logic  valid;
  logic  ready;
  logic  valid_res;
  node_t out_row;
  node_t out_src;
  nw_t   norm_weight;
  logic  error;
  logic  last;
  modport source (output valid, valid_res, out_row, out_src, norm_weight, error, last,
                  input ready);
  modport sink (input valid, valid_res, out_row, out_src, norm_weight, error, last,
                output ready);
endinterface
`default_nettype wire

[design/graph_transition_normalize_unit.sv]
// transition normalize block top level: edge stores, sequencer, shared divider
// depends on gtn_pkg, gtn_in_if, gtn_out_if and the assertion header
`default_nettype none
`include "graph_transition_normalize_unit_assert.svh"
// After reset the block clears its per-node totals and offsets and takes no word
// meanwhile. A load word is taken whenever the block is idle. The first read request
// closes loading: row by row a sum pass and a normalize pass (each weight divided by
// its row sum in the 41-step restoring divider), then a prefix pass over the offsets
// and a scatter pass. Every later read request that finds an edge left uses the
// shared divider again. The result register frees the input side while a word waits
// at the output.
module graph_transition_normalize_unit #(
  parameter int MAX_NODES = gtn_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = gtn_pkg::MAX_EDGES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  gtn_in_if.sink     in_chan,
  gtn_out_if.source  out_chan
);
  import gtn_pkg::*;

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int NCNT_W = $clog2(MAX_NODES + 1);
  localparam int EDGE_W = $clog2(MAX_EDGES);
  localparam int CNT_W  = $clog2(MAX_EDGES + 1);
  localparam int TOT_W  = QW_W + CNT_W;
  localparam int DVS_W  = TOT_W;
  localparam int EW_W   = QW_W + 1;

  typedef enum logic [18:0] {
    S_CLR     = 19'h00001,
    S_IDLE    = 19'h00002,
    S_SUM_RD  = 19'h00004,
    S_SUM_CHK = 19'h00008,
    S_NRM_RD  = 19'h00010,
    S_NRM_LAT = 19'h00020,
    S_NRM_DIV = 19'h00040,
    S_NRM_WR  = 19'h00080,
    S_PFX_RD  = 19'h00100,
    S_PFX_WR  = 19'h00200,
    S_SCT_RD  = 19'h00400,
    S_SCT_OFF = 19'h00800,
    S_SCT_WR  = 19'h01000,
    S_RD_ORD  = 19'h02000,
    S_RD_EDGE = 19'h04000,
    S_RD_TOT  = 19'h08000,
    S_RD_ST   = 19'h10000,
    S_RD_DIV  = 19'h20000,
    S_OUT     = 19'h40000
  } state_t;

  // memories
  logic [NODE_W-1:0] src_mem [MAX_EDGES];
  logic [NODE_W-1:0] dst_mem [MAX_EDGES];
  logic [EW_W-1:0]   wgt_mem [MAX_EDGES];
  logic [EDGE_W-1:0] ord_mem [MAX_EDGES];
  logic [TOT_W-1:0]  tot_mem [MAX_NODES];
  logic [CNT_W-1:0]  off_mem [MAX_NODES];

  logic [NODE_W-1:0] src_rd, dst_rd;
  logic [EW_W-1:0]   wgt_rd;
  logic [EDGE_W-1:0] ord_rd;
  logic [TOT_W-1:0]  tot_rd;
  logic [CNT_W-1:0]  off_rd;

  // control
  state_t            state_r, state_nxt;
  logic              phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [NODE_W-1:0] prev_r, prev_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, rp_r, rp_nxt;
  logic [NCNT_W-1:0] d_r, d_nxt;
  logic [CNT_W-1:0]  acc_r, acc_nxt;
  logic [NODE_W-1:0] row_src_r, row_src_nxt;
  logic [DVS_W-1:0]  sum_r, sum_nxt;
  logic              pend_r, pend_nxt;

  // shared divider
  logic [DVD_W-1:0]  dvd_r, dvd_nxt, quo_r, quo_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt, rem_r, rem_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic              zdiv_r, zdiv_nxt;
  logic [DVS_W:0]    trial;
  logic              ge;

  // result register
  logic              ov_r, ov_nxt;
  logic              o_vres_r, o_vres_nxt, o_err_r, o_err_nxt, o_last_r, o_last_nxt;
  node_t             o_row_r, o_row_nxt, o_src_r, o_src_nxt;
  nw_t               o_nw_r, o_nw_nxt;

  // memory strobes
  logic              e_we, e_re, w_we, o_we, o_re, t_we, t_re, f_we, f_re;
  logic [EDGE_W-1:0] e_wa, e_ra, w_wa, o_wa, o_ra;
  logic [NODE_W-1:0] e_wsrc, e_wdst, t_wa, t_ra, f_wa, f_ra;
  logic [EW_W-1:0]   w_wd;
  logic [EDGE_W-1:0] o_wd;
  logic [TOT_W-1:0]  t_wd;
  logic [CNT_W-1:0]  f_wd;

  logic              src_ok, dst_ok, load_ok;
  logic [NODE_W-1:0] in_src_idx, in_dst_idx;

  assign in_chan.ready = (state_r == S_IDLE);
  assign out_chan.valid       = ov_r;
  assign out_chan.valid_res   = o_vres_r;
  assign out_chan.out_row     = o_row_r;
  assign out_chan.out_src     = o_src_r;
  assign out_chan.norm_weight = o_nw_r;
  assign out_chan.error       = o_err_r;
  assign out_chan.last        = o_last_r;

  assign src_ok = (in_chan.src_node != '0) && (32'(in_chan.src_node) <= MAX_NODES);
  assign dst_ok = (in_chan.dst_node != '0) && (32'(in_chan.dst_node) <= MAX_NODES);
  assign in_src_idx = NODE_W'(in_chan.src_node - 11'd1);
  assign in_dst_idx = NODE_W'(in_chan.dst_node - 11'd1);
  assign load_ok = !phase_r && src_ok && dst_ok && (cnt_r < CNT_W'(MAX_EDGES))
                   && !((cnt_r != '0) && (in_src_idx < prev_r));

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    prev_nxt    = prev_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    rp_nxt      = rp_r;
    d_nxt       = d_r;
    acc_nxt     = acc_r;
    row_src_nxt = row_src_r;
    sum_nxt     = sum_r;
    pend_nxt    = pend_r;
    dvd_nxt     = dvd_r;
    quo_nxt     = quo_r;
    dvs_nxt     = dvs_r;
    rem_nxt     = rem_r;
    dcnt_nxt    = dcnt_r;
    zdiv_nxt    = zdiv_r;
    ov_nxt      = ov_r && !out_chan.ready;
    o_vres_nxt  = o_vres_r;
    o_row_nxt   = o_row_r;
    o_src_nxt   = o_src_r;
    o_nw_nxt    = o_nw_r;
    o_err_nxt   = o_err_r;
    o_last_nxt  = o_last_r;

    e_we = 1'b0; e_re = 1'b0; w_we = 1'b0; o_we = 1'b0; o_re = 1'b0;
    t_we = 1'b0; t_re = 1'b0; f_we = 1'b0; f_re = 1'b0;
    e_wa = cnt_r[EDGE_W-1:0];
    e_ra = j_r[EDGE_W-1:0];
    e_wsrc = in_src_idx;
    e_wdst = in_dst_idx;
    w_wa = cnt_r[EDGE_W-1:0];
    w_wd = EW_W'(in_chan.edge_weight);
    o_wa = off_rd[EDGE_W-1:0];
    o_wd = k_r[EDGE_W-1:0];
    o_ra = rp_r[EDGE_W-1:0];
    t_wa = dst_rd;
    t_ra = dst_rd;
    t_wd = tot_rd + TOT_W'(quo_r[QW_W-1:0]);
    f_wa = dst_rd;
    f_ra = dst_rd;
    f_wd = off_rd + CNT_W'(1);

    // divider step
    if (dcnt_r != '0) begin
      rem_nxt  = ge ? DVS_W'(trial - {1'b0, dvs_r}) : DVS_W'(trial);
      dvd_nxt  = {dvd_r[DVD_W-2:0], 1'b0};
      quo_nxt  = {quo_r[DVD_W-2:0], ge};
      dcnt_nxt = dcnt_r - DCNT_W'(1);
    end

    case (state_r)
      S_CLR: begin
        t_we = 1'b1; f_we = 1'b1;
        t_wa = d_r[NODE_W-1:0]; f_wa = d_r[NODE_W-1:0];
        t_wd = '0; f_wd = '0;
        d_nxt = d_r + NCNT_W'(1);
        if (d_r == NCNT_W'(MAX_NODES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_chan.valid) begin
          if (in_chan.kind == KIND_LOAD) begin
            if (load_ok) begin
              e_we = 1'b1; w_we = 1'b1;
              cnt_nxt = cnt_r + CNT_W'(1);
              prev_nxt = in_src_idx;
            end
          end else if (!phase_r) begin
            i_nxt = '0; j_nxt = '0;
            state_nxt = S_SUM_RD;
          end else begin
            state_nxt = S_RD_ORD;
          end
        end
      end
      S_SUM_RD: begin
        if (j_r == cnt_r) begin
          k_nxt = i_r;
          state_nxt = S_NRM_RD;
        end else begin
          e_re = 1'b1; e_ra = j_r[EDGE_W-1:0];
          state_nxt = S_SUM_CHK;
        end
      end
      S_SUM_CHK: begin
        if (j_r == i_r) begin
          row_src_nxt = src_rd;
          sum_nxt = DVS_W'(wgt_rd[WGT_FW-1:0]);
          j_nxt = j_r + CNT_W'(1);
          state_nxt = S_SUM_RD;
        end else if (src_rd == row_src_r) begin
          sum_nxt = sum_r + DVS_W'(wgt_rd[WGT_FW-1:0]);
          j_nxt = j_r + CNT_W'(1);
          state_nxt = S_SUM_RD;
        end else begin
          k_nxt = i_r;
          state_nxt = S_NRM_RD;
        end
      end
      S_NRM_RD: begin
        if (k_r == j_r) begin
          if (j_r == cnt_r) begin
            d_nxt = '0; acc_nxt = '0;
            state_nxt = S_PFX_RD;
          end else begin
            i_nxt = j_r;
            state_nxt = S_SUM_RD;
          end
        end else begin
          e_re = 1'b1; e_ra = k_r[EDGE_W-1:0];
          state_nxt = S_NRM_LAT;
        end
      end
      S_NRM_LAT: begin
        t_re = 1'b1; f_re = 1'b1;
        if (sum_r == '0) begin
          quo_nxt = '0; zdiv_nxt = 1'b1; dcnt_nxt = '0;
        end else begin
          dvd_nxt = DVD_W'({wgt_rd[WGT_FW-1:0], ROW_SHIFT'(0)});
          dvs_nxt = sum_r; rem_nxt = '0; quo_nxt = '0;
          zdiv_nxt = 1'b0; dcnt_nxt = DCNT_W'(DVD_W);
        end
        state_nxt = S_NRM_DIV;
      end
      S_NRM_DIV: begin
        if (dcnt_r == '0) state_nxt = S_NRM_WR;
      end
      S_NRM_WR: begin
        w_we = 1'b1; w_wa = k_r[EDGE_W-1:0];
        w_wd = {zdiv_r, quo_r[QW_W-1:0]};
        t_we = 1'b1; f_we = 1'b1;
        k_nxt = k_r + CNT_W'(1);
        state_nxt = S_NRM_RD;
      end
      S_PFX_RD: begin
        if (d_r == NCNT_W'(MAX_NODES)) begin
          k_nxt = '0;
          state_nxt = S_SCT_RD;
        end else begin
          f_re = 1'b1; f_ra = d_r[NODE_W-1:0];
          state_nxt = S_PFX_WR;
        end
      end
      S_PFX_WR: begin
        f_we = 1'b1; f_wa = d_r[NODE_W-1:0]; f_wd = acc_r;
        acc_nxt = acc_r + off_rd;
        d_nxt = d_r + NCNT_W'(1);
        state_nxt = S_PFX_RD;
      end
      S_SCT_RD: begin
        if (k_r == cnt_r) begin
          phase_nxt = 1'b1;
          state_nxt = S_RD_ORD;
        end else begin
          e_re = 1'b1; e_ra = k_r[EDGE_W-1:0];
          state_nxt = S_SCT_OFF;
        end
      end
      S_SCT_OFF: begin
        f_re = 1'b1;
        state_nxt = S_SCT_WR;
      end
      S_SCT_WR: begin
        o_we = 1'b1; f_we = 1'b1;
        k_nxt = k_r + CNT_W'(1);
        state_nxt = S_SCT_RD;
      end
      S_RD_ORD: begin
        if (rp_r < cnt_r) begin
          o_re = 1'b1;
          pend_nxt = 1'b1;
          state_nxt = S_RD_EDGE;
        end else begin
          pend_nxt = 1'b0;
          state_nxt = S_OUT;
        end
      end
      S_RD_EDGE: begin
        e_re = 1'b1; e_ra = ord_rd;
        state_nxt = S_RD_TOT;
      end
      S_RD_TOT: begin
        t_re = 1'b1;
        state_nxt = S_RD_ST;
      end
      S_RD_ST: begin
        if (tot_rd == '0) begin
          quo_nxt = '0; zdiv_nxt = 1'b1; dcnt_nxt = '0;
        end else begin
          dvd_nxt = DVD_W'({wgt_rd[QW_W-1:0], COL_SHIFT'(0)});
          dvs_nxt = DVS_W'(tot_rd); rem_nxt = '0; quo_nxt = '0;
          zdiv_nxt = 1'b0; dcnt_nxt = DCNT_W'(DVD_W);
        end
        state_nxt = S_RD_DIV;
      end
      S_RD_DIV: begin
        if (dcnt_r == '0) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || out_chan.ready) begin
          ov_nxt     = 1'b1;
          o_vres_nxt = pend_r;
          o_row_nxt  = pend_r ? NODE_FW'(32'(dst_rd) + 1) : '0;
          o_src_nxt  = pend_r ? NODE_FW'(32'(src_rd) + 1) : '0;
          o_nw_nxt   = pend_r ? quo_r[NW_FW-1:0] : '0;
          o_err_nxt  = pend_r ? (wgt_rd[QW_W] | zdiv_r) : 1'b0;
          o_last_nxt = pend_r && ((rp_r + CNT_W'(1)) == cnt_r);
          if (pend_r) rp_nxt = rp_r + CNT_W'(1);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      phase_r <= 1'b0;
      cnt_r   <= '0;
      prev_r  <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      rp_r    <= '0;
      d_r     <= '0;
      acc_r   <= '0;
      dcnt_r  <= '0;
      ov_r    <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      prev_r  <= prev_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      rp_r    <= rp_nxt;
      d_r     <= d_nxt;
      acc_r   <= acc_nxt;
      dcnt_r  <= dcnt_nxt;
      ov_r    <= ov_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_src_r <= row_src_nxt;
    sum_r     <= sum_nxt;
    dvd_r     <= dvd_nxt;
    quo_r     <= quo_nxt;
    dvs_r     <= dvs_nxt;
    rem_r     <= rem_nxt;
    zdiv_r    <= zdiv_nxt;
    o_vres_r  <= o_vres_nxt;
    o_row_r   <= o_row_nxt;
    o_src_r   <= o_src_nxt;
    o_nw_r    <= o_nw_nxt;
    o_err_r   <= o_err_nxt;
    o_last_r  <= o_last_nxt;
  end

  // edge stores
  always_ff @(posedge clk) begin
    if (e_we) begin
      src_mem[e_wa] <= e_wsrc;
      dst_mem[e_wa] <= e_wdst;
    end
    if (e_re) begin
      src_rd <= src_mem[e_ra];
      dst_rd <= dst_mem[e_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (w_we) wgt_mem[w_wa] <= w_wd;
    if (e_re) wgt_rd <= wgt_mem[e_ra];
  end

  always_ff @(posedge clk) begin
    if (o_we) ord_mem[o_wa] <= o_wd;
    if (o_re) ord_rd <= ord_mem[o_ra];
  end

  // per-node stores
  always_ff @(posedge clk) begin
    if (t_we) tot_mem[t_wa] <= t_wd;
    if (t_re) tot_rd <= tot_mem[t_ra];
  end

  always_ff @(posedge clk) begin
    if (f_we) off_mem[f_wa] <= f_wd;
    if (f_re) off_rd <= off_mem[f_ra];
  end

  `GTN_ASSERT_NEXT(a_phase_sticky, clk, rst_n, phase_r, phase_r)
  `GTN_ASSERT_IMPL(a_div_nonzero, clk, rst_n,
                   (dcnt_r != '0) && !zdiv_r, dvs_r != '0)
  `GTN_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(MAX_EDGES))
  `GTN_ASSERT_NEXT(a_read_leaves_idle, clk, rst_n,
                   in_chan.valid && in_chan.ready && (in_chan.kind == KIND_READ),
                   state_r != S_IDLE)
endmodule
`default_nettype wire
